FILE: sv/mst_pkg.sv
// ----------------------------------------------------------------------------
// mst_pkg
// Shared constants, types and helpers for the Prim spanning tree block.
// ----------------------------------------------------------------------------
package mst_pkg;

    localparam int MAX_NODES   = 16;
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int CNT_BITS    = NODE_BITS + 1;
    localparam int WEIGHT_BITS = 16;
    localparam int COST_BITS   = 20;
    localparam int CFG_BITS    = 5;
    localparam int ADDR_BITS   = 2 * NODE_BITS;
    localparam int MAT_DEPTH   = MAX_NODES * MAX_NODES;

    localparam logic [CFG_BITS-1:0] NODE_COUNT_RESET = CFG_BITS'(16);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SEL,
        ST_UPD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [3:0]  end_a;
        logic [3:0]  end_b;
        logic [15:0] edge_cost;
        logic        final_edge;
    } t_edge;

    typedef struct packed {
        logic [3:0]  node_index;
        logic [3:0]  parent_index;
        logic [15:0] link_cost;
        logic        reached;
        logic [19:0] total_cost;
        logic        last_result;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result data;
    } t_res_req;

    // Edges are stored once, under (lower index, higher index).
    function automatic logic [ADDR_BITS-1:0] pair_addr(input logic [NODE_BITS-1:0] a,
                                                       input logic [NODE_BITS-1:0] b);
        if (a < b) begin
            return {a, b};
        end else begin
            return {b, a};
        end
    endfunction

    function automatic logic [CNT_BITS-1:0] eff_nodes(input logic [CFG_BITS-1:0] cnt);
        if (cnt == '0) begin
            return CNT_BITS'(1);
        end else if (cnt > MAX_NODES) begin
            return CNT_BITS'(MAX_NODES);
        end else begin
            return CNT_BITS'(cnt);
        end
    endfunction

endpackage

FILE: sv/mst_if.sv
// ----------------------------------------------------------------------------
// mst_edge_if / mst_res_if
// Valid/ready channels for edge requests and per-node results.
// ----------------------------------------------------------------------------
interface mst_edge_if;
    logic        valid;
    logic        ready;
    logic [3:0]  end_a;
    logic [3:0]  end_b;
    logic [15:0] edge_cost;
    logic        final_edge;

    modport source (output valid, end_a, end_b, edge_cost, final_edge, input ready);
    modport sink   (input valid, end_a, end_b, edge_cost, final_edge, output ready);
endinterface

interface mst_res_if;
    logic        valid;
    logic        ready;
    logic [3:0]  node_index;
    logic [3:0]  parent_index;
    logic [15:0] link_cost;
    logic        reached;
    logic [19:0] total_cost;
    logic        last_result;

    modport source (output valid, node_index, parent_index, link_cost, reached,
                    total_cost, last_result, input ready);
    modport sink   (input valid, node_index, parent_index, link_cost, reached,
                    total_cost, last_result, output ready);
endinterface

FILE: sv/mst_ram.sv
// ----------------------------------------------------------------------------
// mst_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module mst_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sv/mst_engine.sv
// ----------------------------------------------------------------------------
// mst_engine
// Edge store plus Prim sequencer: one compare unit reused for edge merge,
// minimum search and key relaxation, then a per-node result walk.
// ----------------------------------------------------------------------------
module mst_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [mst_pkg::CNT_BITS-1:0]  i_nodes,
    input  logic                          i_req_valid,
    output logic                          o_req_ready,
    input  mst_pkg::t_edge                i_req,
    output mst_pkg::t_res_req             o_res,
    input  logic                          i_res_take
);
    import mst_pkg::*;

    t_state                               r_state, n_state;
    t_edge                                r_edge;
    logic [ADDR_BITS-1:0]                 r_addr;
    logic [MAT_DEPTH-1:0]                 r_vbit;
    logic [MAX_NODES-1:0]                 r_kvalid;
    logic [MAX_NODES-1:0]                 r_vis;
    logic [MAX_NODES-1:0][NODE_BITS-1:0]  r_par;
    logic [MAX_NODES-1:0][WEIGHT_BITS-1:0] r_key;
    logic [CNT_BITS-1:0]                  r_v;
    logic [NODE_BITS-1:0]                 r_vd;
    logic                                 r_pv;
    logic [NODE_BITS-1:0]                 r_u;
    logic                                 r_found;
    logic [WEIGHT_BITS-1:0]               r_best;
    logic [COST_BITS-1:0]                 r_sum;

    logic [CNT_BITS-1:0]    nodes_m1;
    logic [NODE_BITS-1:0]   v_idx;
    logic [NODE_BITS-1:0]   key_idx;
    logic [WEIGHT_BITS-1:0] key_rd;
    logic                   kv_rd;
    logic                   vis_rd;
    logic [NODE_BITS-1:0]   par_rd;
    logic [WEIGHT_BITS-1:0] ram_rdata;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic                   vbit_rd;
    logic [WEIGHT_BITS-1:0] cmp_a, cmp_b;
    logic                   cmp_lt;
    logic                   edge_ok, load_wr, ram_we, start;
    logic                   sel_hit, sel_last, sel_any;
    logic [NODE_BITS-1:0]   u_next;
    logic                   issuing, upd_hit, upd_done;
    logic                   emit_fire, emit_last, clr;
    logic [WEIGHT_BITS-1:0] link;
    logic                   res_valid;

    assign nodes_m1 = i_nodes - CNT_BITS'(1);
    assign v_idx    = r_v[NODE_BITS-1:0];
    assign key_idx  = (r_state == ST_UPD) ? r_vd : v_idx;
    assign key_rd   = r_key[key_idx];
    assign kv_rd    = r_kvalid[key_idx];
    assign vis_rd   = r_vis[key_idx];
    assign par_rd   = r_par[key_idx];
    assign vbit_rd  = r_vbit[r_addr];

    // shared compare unit
    always_comb begin
        case (r_state)
            ST_LOAD: begin
                cmp_a = r_edge.edge_cost;
                cmp_b = ram_rdata;
            end
            ST_UPD: begin
                cmp_a = ram_rdata;
                cmp_b = key_rd;
            end
            default: begin
                cmp_a = key_rd;
                cmp_b = r_best;
            end
        endcase
    end
    assign cmp_lt = cmp_a < cmp_b;

    assign rd_addr = (r_state == ST_IDLE) ? pair_addr(i_req.end_a, i_req.end_b)
                                          : pair_addr(r_u, v_idx);

    // edge merge
    assign edge_ok = (r_edge.end_a != r_edge.end_b) &&
                     ({1'b0, r_edge.end_a} < i_nodes) && ({1'b0, r_edge.end_b} < i_nodes);
    assign load_wr = edge_ok && (!vbit_rd || cmp_lt);
    assign start   = (r_state == ST_LOAD) && r_edge.final_edge;

    // minimum search, ties keep the lower index
    assign sel_hit  = !vis_rd && kv_rd && (!r_found || cmp_lt);
    assign sel_last = (r_v == nodes_m1);
    assign sel_any  = r_found || sel_hit;
    assign u_next   = sel_hit ? v_idx : r_u;

    // relaxation: address issue, then compare on the registered read data
    assign issuing  = r_v < i_nodes;
    assign upd_hit  = (r_state == ST_UPD) && r_pv && vbit_rd && !vis_rd && (!kv_rd || cmp_lt);
    assign upd_done = !issuing && !r_pv;

    // result walk
    assign emit_last = (r_v == nodes_m1);
    assign emit_fire = (r_state == ST_EMIT) && i_res_take;
    assign clr       = emit_fire && emit_last;
    assign link      = vis_rd ? key_rd : '0;

    always_comb begin
        o_res.valid             = res_valid;
        o_res.data.node_index   = v_idx;
        o_res.data.parent_index = vis_rd ? par_rd : '0;
        o_res.data.link_cost    = link;
        o_res.data.reached      = vis_rd;
        o_res.data.total_cost   = r_sum + COST_BITS'(link);
        o_res.data.last_result  = emit_last;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = r_edge.final_edge ? ST_SEL : ST_IDLE;
            end
            ST_SEL: begin
                if (sel_last) n_state = sel_any ? ST_UPD : ST_EMIT;
            end
            ST_UPD: begin
                if (upd_done) n_state = ST_SEL;
            end
            ST_EMIT: begin
                if (clr) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_req_ready = 1'b0;
        ram_we      = 1'b0;
        res_valid   = 1'b0;
        case (r_state)
            ST_IDLE: o_req_ready = 1'b1;
            ST_LOAD: ram_we      = load_wr;
            ST_EMIT: res_valid   = 1'b1;
            default: ;
        endcase
    end

    mst_ram #(
        .WIDTH (WEIGHT_BITS),
        .DEPTH (MAT_DEPTH)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (r_edge.edge_cost),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr) begin
            r_vbit   <= '0;
            r_kvalid <= '0;
            r_vis    <= '0;
            r_par    <= '0;
        end else begin
            if (ram_we) r_vbit[r_addr] <= 1'b1;
            if (start) r_kvalid[0] <= 1'b1;
            if (r_state == ST_SEL && sel_last && sel_any) r_vis[u_next] <= 1'b1;
            if (upd_hit) begin
                r_kvalid[r_vd] <= 1'b1;
                r_par[r_vd]    <= r_u;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_pv    <= 1'b0;
            r_found <= 1'b0;
            r_sum   <= '0;
        end else begin
            r_pv <= (r_state == ST_UPD) && issuing;
            case (r_state)
                ST_LOAD: begin
                    if (start) begin
                        r_v     <= '0;
                        r_found <= 1'b0;
                        r_sum   <= '0;
                    end
                end
                ST_SEL: begin
                    if (sel_last) begin
                        r_v     <= '0;
                        r_found <= 1'b0;
                    end else begin
                        r_v <= r_v + CNT_BITS'(1);
                        if (sel_hit) r_found <= 1'b1;
                    end
                end
                ST_UPD: begin
                    if (upd_done) begin
                        r_v <= '0;
                    end else if (issuing) begin
                        r_v <= r_v + CNT_BITS'(1);
                    end
                end
                ST_EMIT: begin
                    if (emit_fire) begin
                        r_v   <= emit_last ? '0 : r_v + CNT_BITS'(1);
                        r_sum <= o_res.data.total_cost;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_addr <= rd_addr;
        r_vd   <= v_idx;
        if (r_state == ST_IDLE) r_edge <= i_req;
        if (r_state == ST_SEL) begin
            r_u <= u_next;
            if (sel_hit) r_best <= key_rd;
        end
        if (start) r_key[0] <= '0;
        if (upd_hit) r_key[r_vd] <= ram_rdata;
    end
endmodule

FILE: sv/minimum_spanning_tree_prim_top.sv
// ----------------------------------------------------------------------------
// minimum_spanning_tree_prim_top: Prim spanning tree over a dense edge table
// After an edge request is accepted, ready is low in the load state; a plain edge
// then goes back to idle, a final edge starts the search and the walk of n results
// (n = node count); sync active-low reset clears the table valid bits, no sweep.
// ----------------------------------------------------------------------------
module minimum_spanning_tree_prim_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [mst_pkg::CFG_BITS-1:0]  i_cfg_wdata,
    mst_edge_if.sink                      i_edge,
    mst_res_if.source                     o_res
);
    import mst_pkg::*;

    logic [CFG_BITS-1:0] r_node_count;
    logic [CNT_BITS-1:0] nodes;
    t_edge               req;
    t_res_req            eng_res;
    logic                take;
    logic                eng_ready;
    logic                r_out_valid;
    t_result             r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_wdata;
        end
    end

    assign nodes = eff_nodes(r_node_count);

    always_comb begin
        req.end_a      = i_edge.end_a;
        req.end_b      = i_edge.end_b;
        req.edge_cost  = i_edge.edge_cost;
        req.final_edge = i_edge.final_edge;
    end

    assign i_edge.ready = eng_ready;

    mst_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_nodes     (nodes),
        .i_req_valid (i_edge.valid),
        .o_req_ready (eng_ready),
        .i_req       (req),
        .o_res       (eng_res),
        .i_res_take  (take)
    );

    // output register
    assign take = !r_out_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= eng_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && eng_res.valid) r_out <= eng_res.data;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.node_index   = r_out.node_index;
    assign o_res.parent_index = r_out.parent_index;
    assign o_res.link_cost    = r_out.link_cost;
    assign o_res.reached      = r_out.reached;
    assign o_res.total_cost   = r_out.total_cost;
    assign o_res.last_result  = r_out.last_result;

`ifndef ASSERT_OFF
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_edge.valid && i_edge.ready |=> !i_edge.ready)
        else $error("edge port ready right after a request");

    a_root_reached: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.node_index == '0 |-> o_res.reached)
        else $error("root reported unreached");

    a_unreached_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.reached |-> o_res.link_cost == '0 && o_res.parent_index == '0)
        else $error("unreached node with nonzero link or parent");

    a_sum_covers_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.total_cost >= COST_BITS'(o_res.link_cost))
        else $error("running total below link cost");
`endif
endmodule
